// ===== rtl/sha1md_pkg.sv =====
package sha1md_pkg;

	// Working variables of one compression pass
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} sha1md_vars_t;

	localparam logic [31:0] H0_INIT = 32'h6745_2301;
	localparam logic [31:0] H1_INIT = 32'hEFCD_AB89;
	localparam logic [31:0] H2_INIT = 32'h98BA_DCFE;
	localparam logic [31:0] H3_INIT = 32'h1032_5476;
	localparam logic [31:0] H4_INIT = 32'hC3D2_E1F0;

	localparam logic [31:0] K_0_19  = 32'h5A82_7999;
	localparam logic [31:0] K_20_39 = 32'h6ED9_EBA1;
	localparam logic [31:0] K_40_59 = 32'h8F1B_BCDC;
	localparam logic [31:0] K_60_79 = 32'hCA62_C1D6;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam int unsigned NUM_ROUNDS = 80;
	localparam logic [6:0] LAST_ROUND = 7'(NUM_ROUNDS - 1);

	// Fixed rotations used by the round logic and the message schedule
	function automatic logic [31:0] rotl1(input logic [31:0] x);
		return {x[30:0], x[31]};
	endfunction

	function automatic logic [31:0] rotl5(input logic [31:0] x);
		return {x[26:0], x[31:27]};
	endfunction

	function automatic logic [31:0] rotl30(input logic [31:0] x);
		return {x[1:0], x[31:2]};
	endfunction

endpackage

// ===== rtl/sha1_message_digest.sv =====
// SHA-1 digest of a byte stream, one message byte per input transfer.
// Input channel: data_byte, has_byte, end_of_message with in_valid/in_stall.
// A transfer with has_byte set appends data_byte to the message; a transfer
// with end_of_message set closes it (with no byte, an empty tail is closed).
// Output channel: five transfers per message, digest_word h0..h4 with
// word_index 0..4 and last_word on the fifth, under out_valid/out_stall.
// Bytes are accepted one per cycle while idle; the byte that fills a 64-byte
// block starts a compression (a working variable load, 80 rounds through the
// single round unit, one chaining add). The block buffer is a 16x32 memory
// read one word per round. End of message: padding goes one byte per cycle
// between compressions, the length goes in as two words, and one or two
// compressions come before the first digest word. in_stall is high during
// compressions and from an end transfer until the fifth digest word is taken.
// A stalled receiver just holds the current word. Reset loads the initial hash
// values and clears the length and byte position; no memory clearing is needed.
module sha1_message_digest
	import sha1md_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN_HI,
		ST_LEN_LO,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} state_t;

	state_t       state_q;
	logic [5:0]   pos_q;
	logic [63:0]  len_q;
	logic [23:0]  word_q;
	logic         sent80_q;
	logic         pad_q;
	logic         final_q;
	logic [6:0]   round_q;
	logic [2:0]   idx_q;
	logic [31:0]  h_q [5];
	sha1md_vars_t vars_q;
	sha1md_vars_t vars_nxt;
	logic [31:0]  w_q [16];

	// Block buffer memory
	logic [31:0] mem [16];
	logic        mem_we;
	logic [3:0]  mem_waddr;
	logic [31:0] mem_wdata;
	logic [3:0]  mem_raddr;
	logic [31:0] rdata_q;

	logic        put_en;
	logic [7:0]  put_val;
	logic [31:0] wv;

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = (state_q == ST_EMIT);
	assign digest_word = h_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == 3'd4);

	// Byte insertion: message bytes when idle, padding bytes after the end
	always_comb begin
		put_en  = 1'b0;
		put_val = data_byte;
		case (state_q)
			ST_IDLE: begin
				put_en  = in_valid && has_byte;
				put_val = data_byte;
			end
			ST_PAD: begin
				put_en  = !sent80_q || (pos_q != 6'd56);
				put_val = sent80_q ? 8'h00 : PAD_BYTE;
			end
			default: begin
				put_en  = 1'b0;
				put_val = data_byte;
			end
		endcase
	end

	// Memory write: full words from the byte packer, then the bit length
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q[5:2];
		mem_wdata = {word_q[23:0], put_val};
		case (state_q)
			ST_LEN_HI: begin
				mem_we    = 1'b1;
				mem_waddr = 4'd14;
				mem_wdata = len_q[63:32];
			end
			ST_LEN_LO: begin
				mem_we    = 1'b1;
				mem_waddr = 4'd15;
				mem_wdata = len_q[31:0];
			end
			default: begin
				mem_we = put_en && (pos_q[1:0] == 2'd3);
			end
		endcase
	end

	// Read one word ahead of the round that uses it
	assign mem_raddr = (state_q == ST_ROUND) ? (round_q[3:0] + 4'd1) : 4'd0;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	// Schedule word: from memory for the first 16 rounds, then expanded
	assign wv = (round_q < 7'd16) ? rdata_q : rotl1(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]);

	sha1md_round u_round (
		.round (round_q),
		.cur   (vars_q),
		.w     (wv),
		.nxt   (vars_nxt)
	);

	// Schedule window and working variables (no reset needed)
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			vars_q <= '{a: h_q[0], b: h_q[1], c: h_q[2], d: h_q[3], e: h_q[4]};
		end else if (state_q == ST_ROUND) begin
			vars_q <= vars_nxt;
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= wv;
		end
	end

	// Control, byte packing, length and chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pos_q    <= '0;
			len_q    <= '0;
			word_q   <= '0;
			sent80_q <= 1'b0;
			pad_q    <= 1'b0;
			final_q  <= 1'b0;
			round_q  <= '0;
			idx_q    <= '0;
			h_q[0]   <= H0_INIT;
			h_q[1]   <= H1_INIT;
			h_q[2]   <= H2_INIT;
			h_q[3]   <= H3_INIT;
			h_q[4]   <= H4_INIT;
		end else begin
			if (put_en) begin
				pos_q  <= pos_q + 6'd1;
				word_q <= {word_q[15:0], put_val};
			end
			case (state_q)
				ST_IDLE: begin
					sent80_q <= 1'b0;
					if (in_valid) begin
						if (has_byte) begin
							len_q <= len_q + 64'd8;
						end
						if (put_en && (pos_q == 6'd63)) begin
							pad_q   <= end_of_message;
							state_q <= ST_LOAD;
						end else if (end_of_message) begin
							pad_q   <= 1'b1;
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					if (put_en) begin
						sent80_q <= 1'b1;
						if (pos_q == 6'd63) begin
							state_q <= ST_LOAD;
						end
					end else begin
						state_q <= ST_LEN_HI;
					end
				end
				ST_LEN_HI: begin
					state_q <= ST_LEN_LO;
				end
				ST_LEN_LO: begin
					final_q <= 1'b1;
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					round_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					round_q <= round_q + 7'd1;
					if (round_q == LAST_ROUND) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					h_q[0] <= h_q[0] + vars_q.a;
					h_q[1] <= h_q[1] + vars_q.b;
					h_q[2] <= h_q[2] + vars_q.c;
					h_q[3] <= h_q[3] + vars_q.d;
					h_q[4] <= h_q[4] + vars_q.e;
					if (final_q) begin
						idx_q   <= '0;
						state_q <= ST_EMIT;
					end else if (pad_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (!out_stall) begin
						if (idx_q == 3'd4) begin
							// Last word taken: back to a fresh message
							h_q[0]   <= H0_INIT;
							h_q[1]   <= H1_INIT;
							h_q[2]   <= H2_INIT;
							h_q[3]   <= H3_INIT;
							h_q[4]   <= H4_INIT;
							len_q    <= '0;
							pos_q    <= '0;
							pad_q    <= 1'b0;
							final_q  <= 1'b0;
							sent80_q <= 1'b0;
							idx_q    <= '0;
							state_q  <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/sha1md_round.sv =====
module sha1md_round
	import sha1md_pkg::*;
(
	input  logic [6:0]   round,
	input  sha1md_vars_t cur,
	input  logic [31:0]  w,
	output sha1md_vars_t nxt
);

	logic [31:0] f;
	logic [31:0] k;

	// Round function and constant by round group
	always_comb begin
		if (round < 7'd20) begin
			f = (cur.b & cur.c) | (~cur.b & cur.d);
			k = K_0_19;
		end else if (round < 7'd40) begin
			f = cur.b ^ cur.c ^ cur.d;
			k = K_20_39;
		end else if (round < 7'd60) begin
			f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
			k = K_40_59;
		end else begin
			f = cur.b ^ cur.c ^ cur.d;
			k = K_60_79;
		end
	end

	// Shift the working variables, new a from the five-way sum
	assign nxt.a = rotl5(cur.a) + f + cur.e + k + w;
	assign nxt.b = cur.a;
	assign nxt.c = rotl30(cur.b);
	assign nxt.d = cur.c;
	assign nxt.e = cur.d;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import sha1md_pkg::*;

	localparam int RUN_LIMIT = 200000;
	localparam int TAIL_CYCLES = 300;

	typedef struct {
		logic [7:0] data;
		logic       has;
		logic       eom;
		logic       drain_first;
	} byte_item_t;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        has_byte = 1'b0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	byte_item_t   byte_feed_q[$];
	digest_word_t digest_expect_q[$];
	logic         in_taken = 1'b0;
	int           cycle_count = 0;
	int           err_count = 0;
	int           items_made = 0;
	int           msgs_made = 0;

	// Hash state mirrored on the test side
	logic [31:0] msg_words [16];
	logic [31:0] hash_state [5];
	logic [63:0] msg_bit_count;
	logic [5:0]  msg_byte_pos;

	sha1_message_digest dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.has_byte(has_byte),
		.end_of_message(end_of_message),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.digest_word(digest_word),
		.word_index(word_index),
		.last_word(last_word)
	);

	always #5 clk = ~clk;

	task automatic flag_mismatch(input string what);
		$display("MISMATCH @%0d: %s", cycle_count, what);
		err_count++;
	endtask

	function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic void sha1_restart();
		hash_state[0] = H0_INIT;
		hash_state[1] = H1_INIT;
		hash_state[2] = H2_INIT;
		hash_state[3] = H3_INIT;
		hash_state[4] = H4_INIT;
		msg_bit_count = 64'd0;
		msg_byte_pos = 6'd0;
	endfunction

	// 80 rounds over the current 16-word block
	function automatic void sha1_compress();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, k, wt, t;
		for (int i = 0; i < 16; i++)
			w[i] = msg_words[i];
		a = hash_state[0];
		b = hash_state[1];
		c = hash_state[2];
		d = hash_state[3];
		e = hash_state[4];
		for (int r = 0; r < 80; r++) begin
			if (r < 16) begin
				wt = w[r];
			end else begin
				wt = rol32(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16], 1);
				w[r % 16] = wt;
			end
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = K_0_19;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = K_20_39;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_40_59;
			end else begin
				f = b ^ c ^ d;
				k = K_60_79;
			end
			t = rol32(a, 5) + f + e + k + wt;
			e = d;
			d = c;
			c = rol32(b, 30);
			b = a;
			a = t;
		end
		hash_state[0] += a;
		hash_state[1] += b;
		hash_state[2] += c;
		hash_state[3] += d;
		hash_state[4] += e;
	endfunction

	// Big-endian byte packing; a full block is compressed at once
	function automatic void sha1_absorb(input logic [7:0] b);
		int sh;
		sh = (3 - int'(msg_byte_pos[1:0])) * 8;
		if (msg_byte_pos[1:0] == 2'd0)
			msg_words[msg_byte_pos[5:2]] = {b, 24'h0};
		else
			msg_words[msg_byte_pos[5:2]] |= 32'(b) << sh;
		msg_byte_pos = msg_byte_pos + 6'd1;
		if (msg_byte_pos == 6'd0)
			sha1_compress();
	endfunction

	// One accepted transfer; an end transfer pads and queues the digest
	function automatic void sha1_take_item(input logic [7:0] b, input logic has,
		input logic eom);
		digest_word_t dw;
		if (has) begin
			sha1_absorb(b);
			msg_bit_count += 64'd8;
		end
		if (eom) begin
			sha1_absorb(PAD_BYTE);
			while (msg_byte_pos != 6'd56)
				sha1_absorb(8'h00);
			msg_words[14] = msg_bit_count[63:32];
			msg_words[15] = msg_bit_count[31:0];
			sha1_compress();
			for (int i = 0; i < 5; i++) begin
				dw.word = hash_state[i];
				dw.idx = 3'(i);
				dw.last = (i == 4);
				digest_expect_q.insert(digest_expect_q.size(), dw);
			end
			sha1_restart();
		end
	endfunction

	// Random idling, switched off for a long stretch at regular intervals
	function automatic logic side_idles();
		if ((cycle_count % 5000) >= 1000 && (cycle_count % 5000) < 2000)
			return 1'b0;
		return $urandom_range(99) < 6;
	endfunction

	task automatic push_item(input logic [7:0] b, input logic has, input logic eom,
		input logic drain);
		byte_item_t it;
		it.data = b;
		it.has = has;
		it.eom = eom;
		it.drain_first = drain;
		byte_feed_q.insert(byte_feed_q.size(), it);
		if (has || eom)
			items_made++;
		if (eom)
			msgs_made++;
	endtask

	// Predict on input transfers, check output transfers
	always @(posedge clk) begin
		digest_word_t want;
		if (arst_n) begin
			cycle_count++;
			if (in_valid && in_stall === 1'b0)
				sha1_take_item(data_byte, has_byte, end_of_message);
			in_taken <= in_valid && in_stall === 1'b0;
			if (out_valid === 1'b1 && !out_stall) begin
				if (digest_expect_q.size() == 0) begin
					flag_mismatch($sformatf("unexpected digest word %h index %0d",
						digest_word, word_index));
				end else begin
					want = digest_expect_q.pop_front();
					if (digest_word !== want.word || word_index !== want.idx ||
						last_word !== want.last)
						flag_mismatch($sformatf("got %h/%0d/%b want %h/%0d/%b",
							digest_word, word_index, last_word,
							want.word, want.idx, want.last));
				end
			end
		end
	end

	// Input driver and receiver stall
	always @(negedge clk) begin
		byte_item_t nxt;
		logic go;
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				go = byte_feed_q.size() != 0 && !side_idles();
				if (go && byte_feed_q[0].drain_first && digest_expect_q.size() != 0)
					go = 1'b0;
				if (go) begin
					nxt = byte_feed_q.pop_front();
					in_valid <= 1'b1;
					data_byte <= nxt.data;
					has_byte <= nxt.has;
					end_of_message <= nxt.eom;
				end else begin
					in_valid <= 1'b0;
					data_byte <= 8'($urandom);
					has_byte <= 1'($urandom);
					end_of_message <= 1'($urandom);
				end
			end
			out_stall <= side_idles();
		end
	end

	initial begin
		repeat (RUN_LIMIT) @(posedge clk);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int len;
		int pick;
		logic drain;
		sha1_restart();

		// Directed: empty message, noise, short messages, byte extremes
		push_item(8'hFF, 1'b0, 1'b1, 1'b0);
		push_item(8'hA5, 1'b0, 1'b0, 1'b0);
		push_item(8'h61, 1'b1, 1'b0, 1'b0);
		push_item(8'h62, 1'b1, 1'b0, 1'b0);
		push_item(8'h63, 1'b1, 1'b1, 1'b0);
		push_item(8'h00, 1'b1, 1'b0, 1'b0);
		push_item(8'hFF, 1'b1, 1'b0, 1'b0);
		push_item(8'hFF, 1'b1, 1'b0, 1'b0);
		push_item(8'h00, 1'b0, 1'b1, 1'b0);
		push_item(8'h5A, 1'b0, 1'b0, 1'b0);
		push_item(8'hFF, 1'b1, 1'b1, 1'b0);
		push_item(8'h00, 1'b1, 1'b1, 1'b0);
		push_item(8'h00, 1'b0, 1'b1, 1'b0);

		// Random messages: mostly short, some near the padding boundaries
		while (items_made < 400) begin
			pick = $urandom_range(19);
			if (pick < 14)
				len = $urandom_range(12);
			else if (pick < 19)
				len = $urandom_range(68, 52);
			else
				len = $urandom_range(130, 110);
			drain = (msgs_made == 8);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(99) < 5)
					push_item(8'($urandom), 1'b0, 1'b0, 1'b0);
				if (i == len - 1 && $urandom_range(1))
					push_item(8'($urandom), 1'b1, 1'b1, drain && i == 0);
				else
					push_item(8'($urandom), 1'b1, 1'b0, drain && i == 0);
				drain = drain && i != 0;
			end
			if (byte_feed_q[$].eom == 1'b0)
				push_item(8'($urandom), 1'b0, 1'b1, drain);
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Let everything drain, then wait TAIL_CYCLES further quiet cycles
		while (byte_feed_q.size() != 0 || in_valid)
			@(posedge clk);
		while (digest_expect_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (digest_expect_q.size() != 0)
			flag_mismatch($sformatf("%0d digest words never arrived",
				digest_expect_q.size()));

		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
